[design/qrs_pkg.sv]
package qrs_pkg;

   localparam int COEF_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int DISC_W   = 34;
   localparam int ROOT_W   = 33;
   localparam int SREM_W   = 36;
   localparam int NB_W     = 33;
   localparam int DEN_W    = 17;
   localparam int NUM_W    = 34;
   localparam int SQRT_CELLS = 33;
   localparam int DIV_CELLS  = NUM_W;

   localparam logic [1:0] NAT_NONE   = 2'd0;
   localparam logic [1:0] NAT_ONE    = 2'd1;
   localparam logic [1:0] NAT_TWO    = 2'd2;
   localparam logic [1:0] NAT_LINEAR = 2'd3;

   typedef struct packed {
      logic                     vld;
      logic [1:0]               nature;
      logic signed [DISC_W-1:0] disc;
      logic                     has_min;
      logic signed [NB_W-1:0]   nb;
      logic                     den_neg;
      logic [DEN_W-1:0]         den_mag;
   } item_type;

   typedef struct packed {
      item_type            item;
      logic [DISC_W-1:0]   rad;
      logic [SREM_W-1:0]   rem;
      logic [ROOT_W-1:0]   root;
   } sqrt_type;

   typedef struct packed {
      item_type          item;
      logic [NUM_W-1:0]  num0;
      logic [NUM_W-1:0]  num1;
      logic [DEN_W-1:0]  rem0;
      logic [DEN_W-1:0]  rem1;
      logic [NUM_W-1:0]  quo0;
      logic [NUM_W-1:0]  quo1;
      logic              neg0;
      logic              neg1;
   } div_type;

endpackage

[design/qrs_sqrt_cell.sv]
module qrs_sqrt_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  qrs_pkg::sqrt_type prev,
   output qrs_pkg::sqrt_type next
);
   import qrs_pkg::*;

   sqrt_type            cell_ff;
   sqrt_type            cell_in;
   logic [SREM_W-1:0]   rem_sh;
   logic [SREM_W-1:0]   trial;

   always_comb begin
      rem_sh  = {prev.rem[SREM_W-3:0], prev.rad[DISC_W-1 -: 2]};
      trial   = {1'b0, prev.root, 2'b01};
      cell_in = prev;
      cell_in.rad = {prev.rad[DISC_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         cell_in.rem  = rem_sh - trial;
         cell_in.root = {prev.root[ROOT_W-2:0], 1'b1};
      end else begin
         cell_in.rem  = rem_sh;
         cell_in.root = {prev.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign next = cell_ff;

endmodule

[design/qrs_div_cell.sv]
module qrs_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  qrs_pkg::div_type prev,
   output qrs_pkg::div_type next
);
   import qrs_pkg::*;

   div_type          cell_ff;
   div_type          cell_in;
   logic [DEN_W:0]   r0;
   logic [DEN_W:0]   r1;
   logic [DEN_W:0]   dv;

   always_comb begin
      dv = {1'b0, prev.item.den_mag};
      r0 = {prev.rem0, prev.num0[NUM_W-1]};
      r1 = {prev.rem1, prev.num1[NUM_W-1]};
      cell_in = prev;
      cell_in.num0 = {prev.num0[NUM_W-2:0], 1'b0};
      cell_in.num1 = {prev.num1[NUM_W-2:0], 1'b0};
      if (r0 >= dv) begin
         cell_in.rem0 = DEN_W'(r0 - dv);
         cell_in.quo0 = {prev.quo0[NUM_W-2:0], 1'b1};
      end else begin
         cell_in.rem0 = r0[DEN_W-1:0];
         cell_in.quo0 = {prev.quo0[NUM_W-2:0], 1'b0};
      end
      if (r1 >= dv) begin
         cell_in.rem1 = DEN_W'(r1 - dv);
         cell_in.quo1 = {prev.quo1[NUM_W-2:0], 1'b1};
      end else begin
         cell_in.rem1 = r1[DEN_W-1:0];
         cell_in.quo1 = {prev.quo1[NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else if (en) begin
         cell_ff <= cell_in;
      end
   end

   assign next = cell_ff;

endmodule

[design/quadratic_root_solver_core.sv]
// channel | direction | fields (low bit up)
// req     | in        | tdata: coef_a[15:0] coef_b[31:16] coef_c[47:32]
// rsp     | out       | tuser: nature[1:0]; tdata: disc_value, root_high, root_low,
//         |           |        has_minimum, zero pad
// One transaction per cycle sustained while rsp is ready; the pipe runs input, products,
// discriminant, 33 square root cells, numerator, 34 divider cells, output.
// The square root and divider chains retire one result bit per cell.
// Synchronous active-high reset clears every valid bit.
// A stall at rsp freezes the whole pipe; req_tready follows rsp_tready while a
// result is held.
module quadratic_root_solver_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,  // coef_a, coef_b, coef_c
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,  // nature
   output logic [103:0] rsp_tdata   // disc_value, root_high, root_low, has_minimum
);
   import qrs_pkg::*;

   logic en;

   logic                     va_ff;
   logic signed [COEF_W-1:0] a_ff, b_ff, c_ff;
   logic                     vb_ff;
   logic signed [COEF_W-1:0] ab_ff, bb2_ff;
   logic signed [31:0]       bb_ff, ac_ff;

   logic signed [DISC_W-1:0] disc;
   sqrt_type                 sq_in;
   sqrt_type                 sq [0:SQRT_CELLS];
   div_type                  dv_in;
   div_type                  dv [0:DIV_CELLS];

   logic signed [NUM_W:0]    n0, n1, nbx;
   logic signed [NUM_W-1:0]  q0, q1, hi, lo;
   logic                     out_vld_ff;
   logic [1:0]               nat_ff;
   logic signed [DISC_W-1:0] disc_ff;
   logic signed [NUM_W-1:0]  hi_ff, lo_ff;
   logic                     min_ff;

   assign en = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else if (en) begin
         va_ff <= req_tvalid;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= req_tdata[15:0];
         b_ff   <= req_tdata[31:16];
         c_ff   <= req_tdata[47:32];
         bb_ff  <= 32'(b_ff) * 32'(b_ff);
         ac_ff  <= 32'(a_ff) * 32'(c_ff);
         ab_ff  <= a_ff;
         bb2_ff <= b_ff;
      end
   end

   // discriminant, nature and divisor setup
   always_comb begin
      disc = {{2{bb_ff[31]}}, bb_ff} - {ac_ff, 2'b00};
      sq_in = '0;
      sq_in.item.vld = vb_ff;
      sq_in.item.disc = disc;
      sq_in.item.has_min = (ab_ff > 0);
      sq_in.item.nb = NB_W'(0) - {bb2_ff[COEF_W-1], bb2_ff, {FRAC_W{1'b0}}};
      sq_in.item.den_neg = ab_ff[COEF_W-1];
      sq_in.item.den_mag = ab_ff[COEF_W-1] ? DEN_W'(0) - {ab_ff, 1'b0} : {ab_ff, 1'b0};
      priority if (ab_ff == 0) sq_in.item.nature = NAT_LINEAR;
      else if (disc < 0)       sq_in.item.nature = NAT_NONE;
      else if (disc == 0)      sq_in.item.nature = NAT_ONE;
      else                     sq_in.item.nature = NAT_TWO;
      sq_in.rad = disc[DISC_W-1] ? '0 : disc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq[0] <= '0;
      end else if (en) begin
         sq[0] <= sq_in;
      end
   end

   for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
      qrs_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .prev  (sq[i]),
         .next  (sq[i+1])
      );
   end

   // numerators -b*2^F +/- S as sign and magnitude
   always_comb begin
      nbx = {{2{sq[SQRT_CELLS].item.nb[NB_W-1]}}, sq[SQRT_CELLS].item.nb};
      n0  = nbx + {2'b00, sq[SQRT_CELLS].root};
      n1  = nbx - {2'b00, sq[SQRT_CELLS].root};
      dv_in = '0;
      dv_in.item = sq[SQRT_CELLS].item;
      dv_in.num0 = n0[NUM_W] ? NUM_W'(-n0) : n0[NUM_W-1:0];
      dv_in.num1 = n1[NUM_W] ? NUM_W'(-n1) : n1[NUM_W-1:0];
      dv_in.neg0 = n0[NUM_W] ^ sq[SQRT_CELLS].item.den_neg;
      dv_in.neg1 = n1[NUM_W] ^ sq[SQRT_CELLS].item.den_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv[0] <= '0;
      end else if (en) begin
         dv[0] <= dv_in;
      end
   end

   for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
      qrs_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .prev  (dv[j]),
         .next  (dv[j+1])
      );
   end

   // apply signs, order roots, drop roots that do not exist
   always_comb begin
      q0 = dv[DIV_CELLS].neg0 ? NUM_W'(-dv[DIV_CELLS].quo0) : dv[DIV_CELLS].quo0;
      q1 = dv[DIV_CELLS].neg1 ? NUM_W'(-dv[DIV_CELLS].quo1) : dv[DIV_CELLS].quo1;
      hi = (q0 > q1) ? q0 : q1;
      lo = (q0 > q1) ? q1 : q0;
      if (dv[DIV_CELLS].item.nature == NAT_NONE || dv[DIV_CELLS].item.nature == NAT_LINEAR)
      begin
         hi = '0;
         lo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= dv[DIV_CELLS].item.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nat_ff  <= dv[DIV_CELLS].item.nature;
         disc_ff <= dv[DIV_CELLS].item.disc;
         hi_ff   <= hi;
         lo_ff   <= lo;
         min_ff  <= dv[DIV_CELLS].item.has_min;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = nat_ff;
   assign rsp_tdata  = {1'b0, min_ff, lo_ff, hi_ff, disc_ff};

   a_order : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[67:34]) >= $signed(rsp_tdata[101:68]))
      else $error("root order broken");

   a_noroot : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == NAT_NONE || rsp_tuser == NAT_LINEAR))
      |-> rsp_tdata[101:34] == '0)
      else $error("roots present without real roots");

   a_linear : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == NAT_LINEAR) |-> !rsp_tdata[102])
      else $error("minimum flagged with zero a");

   a_coinc : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == NAT_ONE) |-> rsp_tdata[67:34] == rsp_tdata[101:68])
      else $error("coincident roots differ");

endmodule

[tb/quadratic_root_solver_core_test.sv]
module quadratic_root_solver_core_test;
   import qrs_pkg::*;

   typedef struct {
      logic [1:0]               nature;
      logic signed [DISC_W-1:0] disc;
      logic signed [33:0]       root_hi;
      logic signed [33:0]       root_lo;
      logic                     has_min;
   } roots_type;

   typedef struct {
      logic signed [COEF_W-1:0] a;
      logic signed [COEF_W-1:0] b;
      logic signed [COEF_W-1:0] c;
      bit                       typed;
      roots_type                want;
   } coef_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [47:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [1:0]   rsp_tuser;
   logic [103:0] rsp_tdata;

   roots_type   pending_roots[$];
   int          failures;
   int          rsp_cycles;
   bit          sender_quiet;
   int          nature_seen[4];
   int          sent_items;

   quadratic_root_solver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   // floor(sqrt(d * 4^FRAC_W)), two radicand bits per step
   function automatic longint unsigned frac_sqrt(input longint unsigned d);
      longint unsigned rem, root, pair, trial;
      rem  = 0;
      root = 0;
      for (int i = 31 + FRAC_W; i >= 0; i--) begin
         pair = 0;
         if (i >= FRAC_W)
            pair = (d >> (2 * (i - FRAC_W))) & 3;
         rem   = (rem << 2) | pair;
         trial = (root << 2) | 1;
         root  = root << 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = root | 1;
         end
      end
      return root;
   endfunction

   function automatic roots_type solve_roots(input logic signed [COEF_W-1:0] ca,
                                             input logic signed [COEF_W-1:0] cb,
                                             input logic signed [COEF_W-1:0] cc);
      roots_type r;
      longint a, b, c, d, den, nb, s, r0, r1;
      a = longint'(ca);
      b = longint'(cb);
      c = longint'(cc);
      d = b * b - 4 * a * c;
      r.disc    = DISC_W'(d);
      r.root_hi = '0;
      r.root_lo = '0;
      r.has_min = a > 0;
      if (a == 0) begin
         r.nature = NAT_LINEAR;
      end else if (d < 0) begin
         r.nature = NAT_NONE;
      end else begin
         den = 2 * a;
         nb  = -b * (longint'(1) << FRAC_W);
         if (d == 0) begin
            r.nature  = NAT_ONE;
            r.root_hi = 34'(nb / den);
            r.root_lo = 34'(nb / den);
         end else begin
            s  = longint'(frac_sqrt(d));
            r0 = (nb + s) / den;
            r1 = (nb - s) / den;
            r.nature  = NAT_TWO;
            r.root_hi = 34'(r0 > r1 ? r0 : r1);
            r.root_lo = 34'(r0 > r1 ? r1 : r0);
         end
      end
      return r;
   endfunction

   task automatic send_coefs(input logic signed [COEF_W-1:0] a,
                             input logic signed [COEF_W-1:0] b,
                             input logic signed [COEF_W-1:0] c,
                             input roots_type want);
      @(negedge clock);
      while (!sender_quiet && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c, b, a};
      do @(posedge clock); while (!req_tready);
      pending_roots.push_back(want);
      sent_items++;
   endtask

   // receiver: long hold-off to back the pipe up, then a stretch always ready
   initial begin
      rsp_tready = 1'b0;
      rsp_cycles = 0;
      forever begin
         @(negedge clock);
         rsp_cycles++;
         if (rsp_cycles >= 600 && rsp_cycles < 900)
            rsp_tready <= 1'b0;
         else if (rsp_cycles >= 1200 && rsp_cycles < 1700)
            rsp_tready <= 1'b1;
         else
            rsp_tready <= $urandom_range(99) >= 37;
      end
   end

   always @(posedge clock) begin
      roots_type w;
      logic signed [33:0] got_disc, got_hi, got_lo;
      logic               got_min;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_disc = rsp_tdata[33:0];
         got_hi   = rsp_tdata[67:34];
         got_lo   = rsp_tdata[101:68];
         got_min  = rsp_tdata[102];
         nature_seen[rsp_tuser]++;
         if (pending_roots.size() == 0) begin
            $error("unexpected result transaction, nature %0d", rsp_tuser);
            failures++;
         end else begin
            w = pending_roots.pop_front();
            if (rsp_tuser !== w.nature) begin
               $error("nature: expected %0d, got %0d", w.nature, rsp_tuser);
               failures++;
            end
            if (got_disc !== w.disc) begin
               $error("disc_value: expected %0d, got %0d", w.disc, got_disc);
               failures++;
            end
            if (got_hi !== w.root_hi) begin
               $error("root_high: expected %0d, got %0d", w.root_hi, got_hi);
               failures++;
            end
            if (got_lo !== w.root_lo) begin
               $error("root_low: expected %0d, got %0d", w.root_lo, got_lo);
               failures++;
            end
            if (got_min !== w.has_min) begin
               $error("has_minimum: expected %0d, got %0d", w.has_min, got_min);
               failures++;
            end
         end
      end
   end

   initial begin
      #400000;
      $display("timeout with %0d results outstanding", pending_roots.size());
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      coef_row_type rows[$];
      coef_row_type row;
      roots_type    want;
      logic signed [COEF_W-1:0] a, b, c;
      int        m, k, wait_cycles;

      failures     = 0;
      sent_items   = 0;
      sender_quiet = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // typed rows: not quadratic, no real roots, coincident, both orders of a
      row = '{0, 0, 0, 1, '{NAT_LINEAR, 0, 0, 0, 0}};                rows.push_back(row);
      row = '{0, -32768, 5, 1, '{NAT_LINEAR, 1073741824, 0, 0, 0}};  rows.push_back(row);
      row = '{1, 0, 1, 1, '{NAT_NONE, -4, 0, 0, 1}};                 rows.push_back(row);
      row = '{1, 2, 1, 1, '{NAT_ONE, 0, -65536, -65536, 1}};         rows.push_back(row);
      row = '{1, 0, -1, 1, '{NAT_TWO, 4, 65536, -65536, 1}};         rows.push_back(row);
      row = '{-1, 0, 1, 1, '{NAT_TWO, 4, 65536, -65536, 0}};         rows.push_back(row);
      // extremes and mixed signs, checked by the predictor
      row = '{-32768, -32768, 32767, 0, want};   rows.push_back(row);
      row = '{-32768, 32767, -32768, 0, want};   rows.push_back(row);
      row = '{32767, -32768, -32768, 0, want};   rows.push_back(row);
      row = '{-32768, -32768, -32768, 0, want};  rows.push_back(row);
      row = '{32767, 32767, 32767, 0, want};     rows.push_back(row);
      row = '{1, -32768, -32768, 0, want};       rows.push_back(row);
      row = '{-1, 32767, 32767, 0, want};        rows.push_back(row);
      row = '{32767, 0, 0, 0, want};             rows.push_back(row);
      row = '{-32768, 0, 0, 0, want};            rows.push_back(row);
      row = '{3, 7, -11, 0, want};               rows.push_back(row);
      row = '{-5, 3, 2, 0, want};                rows.push_back(row);
      row = '{2, -3, 1, 0, want};                rows.push_back(row);
      row = '{-7, -1, 13, 0, want};              rows.push_back(row);
      row = '{0, 32767, -1, 0, want};            rows.push_back(row);
      row = '{-1, -2, -1, 0, want};              rows.push_back(row);

      foreach (rows[i]) begin
         want = rows[i].typed ? rows[i].want
                              : solve_roots(rows[i].a, rows[i].b, rows[i].c);
         send_coefs(rows[i].a, rows[i].b, rows[i].c, want);
      end

      for (int n = 0; n < 900; n++) begin
         sender_quiet = (n >= 400 && n < 600);
         case ($urandom_range(7))
            0: begin
               a = '0;
               b = COEF_W'($urandom);
               c = COEF_W'($urandom);
            end
            1, 2: begin
               // perfect square: a*(x+k)^2 scaled, so the discriminant is zero
               m = $urandom_range(8, 1);
               if ($urandom_range(1)) m = -m;
               k = int'($urandom_range(80)) - 40;
               a = COEF_W'(m);
               b = COEF_W'(2 * m * k);
               c = COEF_W'(m * k * k);
            end
            3, 4: begin
               a = COEF_W'(int'($urandom_range(200)) - 100);
               b = COEF_W'(int'($urandom_range(2000)) - 1000);
               c = COEF_W'(int'($urandom_range(2000)) - 1000);
            end
            default: begin
               a = COEF_W'($urandom);
               b = COEF_W'($urandom);
               c = COEF_W'($urandom);
            end
         endcase
         send_coefs(a, b, c, solve_roots(a, b, c));
      end
      sender_quiet = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (pending_roots.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending_roots.size() != 0) begin
         $error("%0d results never arrived", pending_roots.size());
         failures++;
      end
      repeat (100) @(posedge clock);

      $display("%0d coefficient sets solved; results by kind: none %0d, coincident %0d,",
               sent_items, nature_seen[0], nature_seen[1]);
      $display("distinct %0d, not quadratic %0d", nature_seen[2], nature_seen[3]);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

[filelist.f]
design/qrs_pkg.sv
design/qrs_sqrt_cell.sv
design/qrs_div_cell.sv
design/quadratic_root_solver_core.sv
tb/quadratic_root_solver_core_test.sv
